### hw/rtl/pks_pkg.sv
package pks_pkg;

    localparam int VALUE_W       = 16;
    localparam int FLIP_W        = 6;
    localparam int MAX_ITEMS_DEF = 32;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [FLIP_W-1:0] flip_pos;
        logic              end_of_run;
    } t_out_item;

endpackage

### hw/rtl/pancake_sort_flip_sequencer.sv
// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_stall    i_in_data  (value, last)
// output   out        o_out_valid / i_out_stall  o_out_data (flip_pos, end_of_run)
//
// a non-last item is taken without a stall; the last item starts the sort and
// input stalls until the end-of-run item has been handed to the output register
// per position s: read, test and step down; a max scan over 0..s is followed by a
// decide step; per flip an emit step, then two reads and two writes per swapped pair (one read port)
// reset is synchronous, active low; stack contents are not cleared
// output stall only holds the sequencer at its flip emit and end-of-run steps
module pancake_sort_flip_sequencer
    import pks_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;
    logic               out_free;
    logic               out_load;
    t_out_item          out_item;

    pks_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .o_out_data (out_item)
    );

    pks_stack_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pks_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_data      (out_item),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

### hw/rtl/pks_stack_mem.sv
module pks_stack_mem
    import pks_pkg::*;
#(
    parameter int DEPTH = MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pks_out_buf.sv
module pks_out_buf
    import pks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_data,
    output logic      o_free,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      r_valid;
    t_out_item r_data;

    // slot can take a new item when empty or being drained this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

### hw/rtl/pks_ctrl.sv
module pks_ctrl
    import pks_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [VALUE_W-1:0] o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  logic [VALUE_W-1:0] i_rdata,
    input  logic               i_out_free,
    output logic               o_out_load,
    output t_out_item          o_out_data
);

    typedef enum logic [3:0] {
        S_LOAD, S_CHK_RD, S_CHK, S_SCAN, S_DEC, S_EMIT,
        S_FA, S_FB, S_FW1, S_FW2, S_NEXT, S_TERM
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_size, n_size;
    logic [VALUE_W-1:0] r_max, n_max;
    logic [VALUE_W-1:0] r_m, n_m;
    logic [AW-1:0]      r_s, n_s;
    logic [AW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_fend, n_fend;
    logic [AW-1:0]      r_a, n_a;
    logic [AW-1:0]      r_b, n_b;
    logic [VALUE_W-1:0] r_ta, n_ta;
    logic               r_second, n_second;

    // shared magnitude compare
    logic [VALUE_W-1:0] cmp_x, cmp_y;
    logic               cmp_gt;

    logic               accept;
    logic               has_room;
    logic [CW-1:0]      size_now;
    logic [CW-1:0]      flip_diff;

    assign accept    = (r_state == S_LOAD) && i_in_valid;
    assign has_room  = r_cnt < CW'(MAX_ITEMS);
    assign size_now  = has_room ? r_cnt + CW'(1) : r_cnt;
    assign flip_diff = r_size - CW'(r_fend);
    assign cmp_gt    = cmp_x > cmp_y;

    always_comb begin
        case (r_state)
            S_CHK: begin
                cmp_x = r_max;
                cmp_y = i_rdata;
            end
            S_SCAN: begin
                cmp_x = i_rdata;
                cmp_y = r_m;
            end
            default: begin
                cmp_x = i_in_data.value;
                cmp_y = r_max;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_size   = r_size;
        n_max    = r_max;
        n_m      = r_m;
        n_s      = r_s;
        n_i      = r_i;
        n_pos    = r_pos;
        n_fend   = r_fend;
        n_a      = r_a;
        n_b      = r_b;
        n_ta     = r_ta;
        n_second = r_second;

        o_in_stall = (r_state != S_LOAD);
        o_we       = 1'b0;
        o_waddr    = r_cnt[AW-1:0];
        o_wdata    = i_in_data.value;
        o_raddr    = '0;
        o_out_load = 1'b0;
        o_out_data.flip_pos   = FLIP_W'(flip_diff);
        o_out_data.end_of_run = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (has_room) begin
                        o_we  = 1'b1;
                        n_cnt = size_now;
                        if (cmp_gt) begin
                            n_max = i_in_data.value;
                        end
                    end
                    if (i_in_data.last) begin
                        n_size = size_now;
                        n_s    = AW'(size_now - CW'(1));
                        if (size_now == CW'(1)) begin
                            n_state = S_TERM;
                        end else begin
                            n_state = S_CHK_RD;
                        end
                    end
                end
            end
            S_CHK_RD: begin
                o_raddr = r_s;
                n_state = S_CHK;
            end
            S_CHK: begin
                // element at s below the running max: scan 0..s
                o_raddr = '0;
                if (cmp_gt) begin
                    n_i     = '0;
                    n_m     = '0;
                    n_pos   = r_s;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SCAN: begin
                o_raddr = r_i + AW'(1);
                if (cmp_gt) begin
                    n_m   = i_rdata;
                    n_pos = r_i;
                end
                n_i = r_i + AW'(1);
                if (r_i == r_s) begin
                    n_max   = cmp_gt ? i_rdata : r_m;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_pos == '0) begin
                    n_fend   = r_s;
                    n_second = 1'b0;
                    n_state  = S_EMIT;
                end else if (r_pos != r_s) begin
                    n_fend   = r_pos;
                    n_second = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_a        = '0;
                    n_b        = r_fend;
                    n_state    = S_FA;
                end
            end
            S_FA: begin
                o_raddr = r_a;
                n_state = S_FB;
            end
            S_FB: begin
                o_raddr = r_b;
                n_ta    = i_rdata;
                n_state = S_FW1;
            end
            S_FW1: begin
                o_we    = 1'b1;
                o_waddr = r_a;
                o_wdata = i_rdata;
                n_state = S_FW2;
            end
            S_FW2: begin
                o_we    = 1'b1;
                o_waddr = r_b;
                o_wdata = r_ta;
                n_a     = r_a + AW'(1);
                n_b     = r_b - AW'(1);
                if (({1'b0, r_a} + (AW+1)'(2)) < {1'b0, r_b}) begin
                    n_state = S_FA;
                end else if (r_second) begin
                    n_second = 1'b0;
                    n_fend   = r_s;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_s == AW'(1)) begin
                    n_state = S_TERM;
                end else begin
                    n_s     = r_s - AW'(1);
                    n_state = S_CHK_RD;
                end
            end
            S_TERM: begin
                o_out_data.flip_pos   = '0;
                o_out_data.end_of_run = 1'b1;
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_cnt      = '0;
                    n_max      = '0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_max    <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_max    <= n_max;
            r_second <= n_second;
        end
        r_size <= n_size;
        r_m    <= n_m;
        r_s    <= n_s;
        r_i    <= n_i;
        r_pos  <= n_pos;
        r_fend <= n_fend;
        r_a    <= n_a;
        r_b    <= n_b;
        r_ta   <= n_ta;
    end

endmodule
